// ----- design/pehv_pkg.sv -----
package pehv_pkg;

  localparam int unsigned MAX_SECTIONS = 96;
  localparam int unsigned EARLY_DEPTH = 64;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [15:0] DOS_MAGIC = 16'h5A4D;
  localparam logic [31:0] NT_MAGIC = 32'h0000_4550;
  localparam logic [15:0] PE32PLUS_MAGIC = 16'h020B;
  localparam logic [15:0] OPT_MIN_BYTES = 16'd60;
  localparam logic [5:0] SECTION_BYTES = 6'd40;

  // header byte positions relative to the nt signature
  localparam logic [6:0] REL_SIGNATURE = 7'd3;
  localparam logic [6:0] REL_SECTION_COUNT = 7'd7;
  localparam logic [6:0] REL_OPT_SIZE = 7'd21;
  localparam logic [6:0] REL_OPT_MAGIC = 7'd25;
  localparam logic [6:0] REL_ENTRY = 7'd43;
  localparam logic [6:0] REL_BASE = 7'd55;
  localparam logic [6:0] REL_IMAGE_SIZE = 7'd83;
  localparam logic [31:0] HEADER_BYTES = 32'd84;

  // byte positions inside one section header
  localparam logic [5:0] OFF_VSIZE = 6'd11;
  localparam logic [5:0] OFF_RVA = 6'd15;
  localparam logic [5:0] OFF_RSIZE = 6'd19;
  localparam logic [5:0] OFF_ROFF = 6'd23;
  localparam logic [5:0] OFF_FLAGS = 6'd39;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_SECTION = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  typedef enum logic [1:0] {
    F_RUN,
    F_READ,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_SECTIONS,
    PH_DONE
  } phase_t;

  // one unit of work handed from the front to the back
  typedef struct packed {
    logic        nt;
    logic        final_byte;
    logic [7:0]  data;
    logic [31:0] rel;
    logic [31:0] hoff;
  } op_t;

endpackage

// ----- design/pehv_front.sv -----
module pehv_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    image_byte,
  input  logic [31:0]   image_length,
  input  logic          q_full,
  output logic          push,
  output pehv_pkg::op_t push_op
);
  import pehv_pkg::*;

  front_state_t state, state_next;
  logic [31:0] pos;
  logic [31:0] hoff;
  logic [31:0] shreg;
  logic        dos_fail;
  logic [5:0]  rptr;
  logic        fin_saved;
  logic [7:0]  early [EARLY_DEPTH];
  logic [7:0]  rdata;

  logic [31:0] sh_n;
  logic        accept;
  logic        is_final;
  logic        early_pos;
  logic        start_replay;
  logic        nt_byte;

  assign accept = in_valid && !in_stall;
  assign sh_n = {image_byte, shreg[31:8]};
  assign is_final = ({1'b0, pos} + 33'd1) >= {1'b0, image_length};
  assign early_pos = pos < 32'(EARLY_DEPTH);
  assign start_replay = !dos_fail && pos == 32'(EARLY_DEPTH - 1) && sh_n < 32'(EARLY_DEPTH);
  assign nt_byte = !dos_fail && !early_pos && pos >= hoff;

  always_comb begin
    state_next = state;
    case (state)
      F_RUN: if (accept && start_replay) state_next = F_READ;
      F_READ: state_next = F_PUSH;
      F_PUSH: begin
        if (!q_full) state_next = (rptr == 6'(EARLY_DEPTH - 1)) ? F_RUN : F_READ;
      end
      default: state_next = F_RUN;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    push = 1'b0;
    push_op = '0;
    case (state)
      F_RUN: begin
        in_stall = q_full;
        push = accept && !start_replay && (nt_byte || is_final);
        push_op.nt = nt_byte;
        push_op.final_byte = is_final;
        push_op.data = image_byte;
        push_op.rel = pos - hoff;
        push_op.hoff = hoff;
      end
      F_PUSH: begin
        push = !q_full;
        push_op.nt = 1'b1;
        push_op.final_byte = fin_saved && rptr == 6'(EARLY_DEPTH - 1);
        push_op.data = rdata;
        push_op.rel = {26'd0, rptr - hoff[5:0]};
        push_op.hoff = hoff;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && early_pos && !dos_fail) early[pos[5:0]] <= image_byte;
    rdata <= early[rptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_RUN;
      pos <= '0;
      hoff <= '0;
      shreg <= '0;
      dos_fail <= 1'b0;
      rptr <= '0;
      fin_saved <= 1'b0;
    end else begin
      state <= state_next;
      if (state == F_RUN && accept) begin
        if (is_final) begin
          pos <= '0;
          shreg <= '0;
          dos_fail <= 1'b0;
          // a replay still needs the offset, it is cleared when the replay ends
          hoff <= start_replay ? sh_n : '0;
        end else begin
          pos <= pos + 32'd1;
          if (early_pos && !dos_fail) begin
            shreg <= sh_n;
            if (pos == 32'd1 && sh_n[31:16] != DOS_MAGIC) dos_fail <= 1'b1;
            if (pos == 32'(EARLY_DEPTH - 1)) hoff <= sh_n;
          end
        end
        if (start_replay) begin
          rptr <= sh_n[5:0];
          fin_saved <= is_final;
        end
      end
      if (state == F_PUSH && !q_full) begin
        rptr <= rptr + 6'd1;
        if (fin_saved && rptr == 6'(EARLY_DEPTH - 1)) hoff <= '0;
      end
    end
  end

endmodule

// ----- design/pehv_queue.sv -----
module pehv_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pehv_pkg::op_t push_op,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output pehv_pkg::op_t head_op
);
  import pehv_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);

  op_t             slots [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [PW:0]     count;

  assign full = count == (PW + 1)'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_op = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (PW + 1)'(push) - (PW + 1)'(pop);
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !head_valid |-> !pop)
    else $error("queue read while empty");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count did not advance");
`endif

endmodule

// ----- design/pehv_back.sv -----
module pehv_back (
  input  logic          clk,
  input  logic          rst,
  input  logic [31:0]   image_length,
  input  logic          head_valid,
  input  pehv_pkg::op_t head_op,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [1:0]    record_kind,
  output logic [63:0]   base_address,
  output logic [31:0]   mapped_size,
  output logic [31:0]   entry_point,
  output logic [31:0]   section_address,
  output logic [31:0]   section_mem_size,
  output logic [31:0]   section_file_offset,
  output logic [31:0]   section_file_size,
  output logic [31:0]   section_flags,
  output logic          status,
  output logic          run_end
);
  import pehv_pkg::*;

  phase_t      phase, phase_next;
  logic        failed, failed_next;
  logic [63:0] sh;
  logic [6:0]  count;
  logic [15:0] opt_size;
  logic [31:0] img_size;
  logic [31:0] entry;
  logic [63:0] base;
  logic [6:0]  sidx;
  logic [31:0] cap_rva, cap_vsz, cap_roff, cap_rsz;
  logic [16:0] sec_base;
  logic        pend;
  logic        pend_status;

  logic        out_free;
  logic [63:0] sh_n;
  logic [32:0] diff;
  logic [5:0]  off;
  logic        act, hdr_act, sec_act;
  logic        hdr_go, sec_go;
  logic [33:0] span;
  logic        final_status;

  assign out_free = !out_valid || !out_stall;
  assign pop = head_valid && out_free && !pend;
  assign sh_n = {head_op.data, sh[63:8]};
  assign diff = {1'b0, head_op.rel} - {16'd0, sec_base};
  assign off = diff[5:0];
  assign act = pop && head_op.nt && !failed;
  assign hdr_act = act && phase == PH_HEADER && head_op.rel < HEADER_BYTES;
  assign sec_act = act && phase == PH_SECTIONS && !diff[32] &&
                   diff[31:0] < {26'd0, SECTION_BYTES};
  assign span = {2'd0, head_op.hoff} + 34'd24 + {18'd0, opt_size} +
                {22'd0, count, 5'd0} + {24'd0, count, 3'd0};

  always_comb begin
    failed_next = failed;
    phase_next = phase;
    hdr_go = 1'b0;
    sec_go = 1'b0;
    if (hdr_act) begin
      case (head_op.rel[6:0])
        REL_SIGNATURE: if (sh_n[63:32] != NT_MAGIC) failed_next = 1'b1;
        REL_SECTION_COUNT: begin
          if (sh_n[63:48] == 16'd0 || sh_n[63:48] > 16'(MAX_SECTIONS)) failed_next = 1'b1;
        end
        REL_OPT_SIZE: if (sh_n[63:48] < OPT_MIN_BYTES) failed_next = 1'b1;
        REL_OPT_MAGIC: if (sh_n[63:48] != PE32PLUS_MAGIC) failed_next = 1'b1;
        REL_IMAGE_SIZE: begin
          if (sh_n[63:32] == 32'd0 || entry >= sh_n[63:32] ||
              span > {2'd0, image_length}) begin
            failed_next = 1'b1;
          end else begin
            hdr_go = 1'b1;
            phase_next = PH_SECTIONS;
          end
        end
        default: ;
      endcase
    end
    if (sec_act && off == OFF_FLAGS) begin
      if (cap_rva >= img_size || cap_vsz > img_size - cap_rva ||
          cap_roff > image_length || cap_rsz > image_length - cap_roff) begin
        failed_next = 1'b1;
      end else begin
        sec_go = 1'b1;
        if (sidx + 7'd1 >= count) phase_next = PH_DONE;
      end
    end
  end

  assign final_status = failed_next || phase_next != PH_DONE;

  // parser state
  always_ff @(posedge clk) begin
    if (rst || (pop && head_op.final_byte)) begin
      phase <= PH_HEADER;
      failed <= 1'b0;
      sh <= '0;
      count <= '0;
      opt_size <= '0;
      img_size <= '0;
      entry <= '0;
      base <= '0;
      sidx <= '0;
      cap_rva <= '0;
      cap_vsz <= '0;
      cap_roff <= '0;
      cap_rsz <= '0;
      sec_base <= '0;
    end else begin
      phase <= phase_next;
      failed <= failed_next;
      if (hdr_act || sec_act) sh <= sh_n;
      if (hdr_act) begin
        case (head_op.rel[6:0])
          REL_SECTION_COUNT: count <= sh_n[54:48];
          REL_OPT_SIZE: opt_size <= sh_n[63:48];
          REL_ENTRY: entry <= sh_n[63:32];
          REL_BASE: base <= sh_n;
          REL_IMAGE_SIZE: img_size <= sh_n[63:32];
          default: ;
        endcase
      end
      if (hdr_go) sec_base <= 17'd24 + {1'b0, opt_size};
      if (sec_act) begin
        case (off)
          OFF_VSIZE: cap_vsz <= sh_n[63:32];
          OFF_RVA: cap_rva <= sh_n[63:32];
          OFF_RSIZE: cap_rsz <= sh_n[63:32];
          OFF_ROFF: cap_roff <= sh_n[63:32];
          default: ;
        endcase
      end
      if (sec_go) begin
        sidx <= sidx + 7'd1;
        sec_base <= sec_base + {11'd0, SECTION_BYTES};
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend <= 1'b0;
      pend_status <= 1'b0;
    end else if (pend && out_free) begin
      out_valid <= 1'b1;
      pend <= 1'b0;
    end else if (pop && (hdr_go || sec_go || head_op.final_byte)) begin
      out_valid <= 1'b1;
      pend <= (hdr_go || sec_go) && head_op.final_byte;
      pend_status <= final_status;
    end else if (out_free) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend && out_free) begin
      record_kind <= KIND_STATUS;
      base_address <= '0;
      mapped_size <= '0;
      entry_point <= '0;
      section_address <= '0;
      section_mem_size <= '0;
      section_file_offset <= '0;
      section_file_size <= '0;
      section_flags <= '0;
      status <= pend_status;
      run_end <= 1'b1;
    end else if (pop && (hdr_go || sec_go || head_op.final_byte)) begin
      record_kind <= hdr_go ? KIND_HEADER : (sec_go ? KIND_SECTION : KIND_STATUS);
      base_address <= hdr_go ? base : '0;
      mapped_size <= hdr_go ? sh_n[63:32] : '0;
      entry_point <= hdr_go ? entry : '0;
      section_address <= sec_go ? cap_rva : '0;
      section_mem_size <= sec_go ? cap_vsz : '0;
      section_file_offset <= sec_go ? cap_roff : '0;
      section_file_size <= sec_go ? cap_rsz : '0;
      section_flags <= sec_go ? sh_n[63:32] : '0;
      status <= (hdr_go || sec_go) ? 1'b0 : final_status;
      run_end <= !((hdr_go || sec_go) && head_op.final_byte);
    end
  end

`ifndef SYNTH
  a_hold_when_pending: assert property (@(posedge clk) disable iff (rst) pend |-> !pop)
    else $error("op consumed while a status is pending");
  a_pend_has_record: assert property (@(posedge clk) disable iff (rst)
    $rose(pend) |-> out_valid && record_kind != KIND_STATUS)
    else $error("pending status without a preceding record");
  a_sections_bounded: assert property (@(posedge clk) disable iff (rst)
    phase == PH_SECTIONS |-> sidx < count)
    else $error("section index past section count");
`endif

endmodule

// ----- design/pe32plus_header_validator_core.sv -----
// a byte transfer reaches its first result through a queue slot, then the output register
// throughput: one image byte per cycle while the queue is not full and no replay runs
// when the header offset is below 64, byte 63 triggers a replay of the stored early bytes:
//   each replayed byte takes a memory read, then a queue push, input stalled meanwhile
// reset: synchronous, clears control state and sets image_length to 1;
//   the early byte memory is not cleared (only bytes written in the current image are read)
module pe32plus_header_validator_core (
  input  logic        clk,
  input  logic        rst,
  // byte channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  image_byte,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  // record channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  record_kind,
  output logic [63:0] base_address,
  output logic [31:0] mapped_size,
  output logic [31:0] entry_point,
  output logic [31:0] section_address,
  output logic [31:0] section_mem_size,
  output logic [31:0] section_file_offset,
  output logic [31:0] section_file_size,
  output logic [31:0] section_flags,
  output logic        status,
  output logic        run_end
);
  import pehv_pkg::*;

  logic [31:0] image_length;
  logic        push;
  op_t         push_op;
  logic        q_full;
  logic        pop;
  logic        head_valid;
  op_t         head_op;

  // length register; write it only while idle (the block itself does not enforce this)
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_length <= 32'd1;
    end else if (cfg_valid && cfg_ready) begin
      image_length <= cfg_data;
    end
  end

  // front: byte position, dos header, early byte store and replay
  pehv_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .image_byte   (image_byte),
    .image_length (image_length),
    .q_full       (q_full),
    .push         (push),
    .push_op      (push_op)
  );

  // short queue so each side stalls on its own
  pehv_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_op    (push_op),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_op    (head_op)
  );

  // back: nt header and section checks, record output
  pehv_back u_back (
    .clk                 (clk),
    .rst                 (rst),
    .image_length        (image_length),
    .head_valid          (head_valid),
    .head_op             (head_op),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .record_kind         (record_kind),
    .base_address        (base_address),
    .mapped_size         (mapped_size),
    .entry_point         (entry_point),
    .section_address     (section_address),
    .section_mem_size    (section_mem_size),
    .section_file_offset (section_file_offset),
    .section_file_size   (section_file_size),
    .section_flags       (section_flags),
    .status              (status),
    .run_end             (run_end)
  );

endmodule
